// ----- hw/rtl/fixed_width_histogram_assert.svh -----
`ifndef FIXED_WIDTH_HISTOGRAM_ASSERT_SVH
`define FIXED_WIDTH_HISTOGRAM_ASSERT_SVH

// Same-cycle implication.
`define FWH_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwh: same-cycle check failed");

// Next-cycle implication.
`define FWH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwh: next-cycle check failed");

// Condition that must never be seen.
`define FWH_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fwh: forbidden condition seen");

`endif

// ----- hw/rtl/fwh_pkg.sv -----
`timescale 1ns / 1ps

package fwh_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int MAX_BINS    = 64;
    localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
    localparam int BIN_AW      = $clog2(MAX_BINS);
    localparam int TOTAL_W     = SAMPLE_AW + 1;

    localparam int SAMPLE_W    = 32;
    localparam int BINW_W      = 31;
    localparam int RUN_W       = 33;   // sample plus half width
    localparam int QUO_W       = 34;   // signed bin index of an edge
    localparam int OFF_W       = 35;   // sample distance from floored low edge
    localparam int EDGE_W      = 41;
    localparam int COUNT_W     = 13;
    localparam int FRAC_W      = 17;
    localparam int FRAC_SHIFT  = 16;
    localparam int DIV_W       = 33;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    typedef logic        [SAMPLE_W-1:0]  sample_t;
    typedef logic        [BINW_W-1:0]    width_t;
    typedef logic        [TOTAL_W-1:0]   total_t;
    typedef logic signed [RUN_W-1:0]     run_t;
    typedef logic signed [QUO_W-1:0]     quo_t;
    typedef logic signed [OFF_W-1:0]     off_t;
    typedef logic signed [EDGE_W-1:0]    edge_t;
    typedef logic        [COUNT_W-1:0]   count_t;
    typedef logic        [FRAC_W-1:0]    frac_t;
    typedef logic        [BIN_AW-1:0]    bin_idx_t;
    typedef logic        [DIV_W-1:0]     div_word_t;
    typedef logic        [DIV_CNT_W-1:0] div_cnt_t;

    localparam width_t BIN_WIDTH_RESET = 31'd256;
    localparam width_t WIDTH_MIN       = 31'd2;
    localparam width_t WIDTH_MAX       = 31'h4000_0000;
    localparam total_t TOTAL_MAX       = total_t'(MAX_SAMPLES);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } item_t;

    typedef struct packed {
        logic signed [EDGE_W-1:0] bin_low;
        logic [COUNT_W-1:0]       bin_count;
        logic [FRAC_W-1:0]        bin_fraction;
        logic                     span_clamped;
        logic                     last_bin;
    } result_t;

    typedef struct packed {
        logic      start;
        logic      short_mode;   // quotient known to fit in BIN_AW bits
        div_word_t dividend;
        width_t    divisor;
    } div_req_t;

    typedef struct packed {
        logic      done;
        div_word_t quotient;
        width_t    remainder;
    } div_rsp_t;

endpackage

// ----- hw/rtl/fixed_width_histogram.sv -----
`timescale 1ns / 1ps
`include "fixed_width_histogram_assert.svh"

// Fixed-width histogram of signed samples.
// Request channel: a request (sample, last_sample) is taken on a clock edge with start
// high and busy low. Samples without last_sample load into the sample RAM at one per
// cycle and busy stays low. A request with last_sample set starts the run; busy then
// stays high until the last bin result has gone out. Samples past the 4096-entry store
// are dropped, but their last_sample flag still starts the run.
// Config: cfg_we/cfg_data write bin_width (reset 256, clamped to 2..2^30 in use).
// Results: one per bin on result, flagged by result_valid for exactly one cycle; the
// receiver cannot stall, so nothing is held back. result.last_bin marks the end.
// Run phases (N stored samples, B bins), all using the shared serial divider:
//   edge setup    two 33-step divides of the running min/max
//   bin counting  per sample: RAM read, a 6-step divide only when its bin needs one,
//                 then a count RAM read-modify-write
//   result output per bin: count RAM read plus a 33-step fraction divide
// Bin counts live in a 64-entry RAM with one valid bit per entry; the valid bits
// all clear together at the end of a run, so no clearing pass is needed.
// Reset: bin_width back to 256, the set empties, busy low. The sample RAM is not
// cleared; only entries written in the current set are read.
module fixed_width_histogram (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fwh_pkg::item_t   item,
    input  logic             cfg_we,
    input  fwh_pkg::width_t  cfg_data,
    output logic             result_valid,
    output fwh_pkg::result_t result
);

    typedef enum logic [3:0] {
        IDLE,
        LO_GO,
        LO_WAIT,
        HI_GO,
        HI_WAIT,
        NBINS,
        S_RD,
        S_IDX,
        S_DIVW,
        C_RD,
        C_WR,
        O_RD,
        O_DIV,
        O_WAIT
    } state_t;

    state_t                         state_reg;
    fwh_pkg::width_t                bin_width_reg;
    fwh_pkg::total_t                total_reg;
    fwh_pkg::run_t                  run_low_reg;
    fwh_pkg::run_t                  run_high_reg;
    fwh_pkg::quo_t                  fl_reg;
    fwh_pkg::quo_t                  ce_reg;
    fwh_pkg::quo_t                  lo_reg;
    fwh_pkg::off_t                  off_reg;
    fwh_pkg::bin_idx_t              last_idx_reg;
    logic                           clamped_reg;
    fwh_pkg::total_t                k_reg;
    fwh_pkg::bin_idx_t              bin_idx_reg;
    fwh_pkg::bin_idx_t              out_idx_reg;
    fwh_pkg::count_t                cnt_reg;
    fwh_pkg::edge_t                 edge_reg;
    logic [fwh_pkg::MAX_BINS-1:0]   valid_reg;
    fwh_pkg::result_t               result_reg;
    logic                           result_valid_reg;

    // effective width and offset
    fwh_pkg::width_t                w_eff;
    fwh_pkg::width_t                half;
    fwh_pkg::run_t                  v;
    logic                           accept;

    // sample store
    logic                           store_we;
    fwh_pkg::sample_t               store_rdata;

    // count store
    logic                           cnt_we;
    fwh_pkg::bin_idx_t              cnt_raddr;
    fwh_pkg::count_t                cnt_rdata;
    fwh_pkg::count_t                cnt_old;
    fwh_pkg::count_t                cnt_inc;
    fwh_pkg::count_t                cnt_val;

    // edge math
    fwh_pkg::run_t                  run_sel;
    fwh_pkg::div_word_t             run_mag;
    fwh_pkg::quo_t                  q_s;
    logic                           rem_nz;
    fwh_pkg::width_t                rr;
    fwh_pkg::quo_t                  fl_calc;
    fwh_pkg::quo_t                  lo_calc;
    fwh_pkg::quo_t                  ce_calc;
    fwh_pkg::off_t                  span;
    logic                           span_big;
    fwh_pkg::off_t                  off_calc;

    // per-sample index
    fwh_pkg::off_t                  d;
    logic [fwh_pkg::BINW_W+fwh_pkg::BIN_AW-1:0] d_ext;
    logic [fwh_pkg::BINW_W+fwh_pkg::BIN_AW-1:0] d_lim;
    logic                           d_neg;
    logic                           d_big;
    fwh_pkg::bin_idx_t              q_idx;
    fwh_pkg::bin_idx_t              q_idx_clamped;

    fwh_pkg::div_req_t              div_req;
    fwh_pkg::div_rsp_t              div_rsp;

    // set emptied and block idle
    logic                           run_idle;

    always_comb
    begin
        if (bin_width_reg < fwh_pkg::WIDTH_MIN)
        begin
            w_eff = fwh_pkg::WIDTH_MIN;
        end
        else if (bin_width_reg > fwh_pkg::WIDTH_MAX)
        begin
            w_eff = fwh_pkg::WIDTH_MAX;
        end
        else
        begin
            w_eff = bin_width_reg;
        end
    end

    assign half     = w_eff >> 1;
    assign v        = fwh_pkg::run_t'(item.sample) + fwh_pkg::run_t'(half);
    assign busy     = (state_reg != IDLE);
    assign accept   = start && !busy;
    assign store_we = accept && (total_reg < fwh_pkg::TOTAL_MAX);

    fwh_ram #(
        .WIDTH (fwh_pkg::SAMPLE_W),
        .DEPTH (fwh_pkg::MAX_SAMPLES)
    ) u_sample_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (total_reg[fwh_pkg::SAMPLE_AW-1:0]),
        .wdata (item.sample),
        .raddr (k_reg[fwh_pkg::SAMPLE_AW-1:0]),
        .rdata (store_rdata)
    );

    // Counts: read in C_RD / O_RD, written back in C_WR. Only one sample is in
    // flight, so a read never races a write to the same bin.
    assign cnt_we    = (state_reg == C_WR);
    assign cnt_raddr = (state_reg == O_RD) ? out_idx_reg : bin_idx_reg;
    assign cnt_old   = valid_reg[bin_idx_reg] ? cnt_rdata : '0;
    assign cnt_inc   = cnt_old + fwh_pkg::count_t'(1);
    assign cnt_val   = valid_reg[out_idx_reg] ? cnt_rdata : '0;

    fwh_ram #(
        .WIDTH (fwh_pkg::COUNT_W),
        .DEPTH (fwh_pkg::MAX_BINS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (bin_idx_reg),
        .wdata (cnt_inc),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Floor of the min and ceiling of the max from magnitude, quotient, remainder.
    assign run_sel = (state_reg == LO_GO) ? run_low_reg : run_high_reg;
    assign run_mag = run_sel[fwh_pkg::RUN_W-1] ? fwh_pkg::div_word_t'(-run_sel)
                                               : fwh_pkg::div_word_t'(run_sel);
    assign q_s     = fwh_pkg::quo_t'(div_rsp.quotient);
    assign rem_nz  = |div_rsp.remainder;

    always_comb
    begin
        if (!run_low_reg[fwh_pkg::RUN_W-1])
        begin
            rr = div_rsp.remainder;
        end
        else if (rem_nz)
        begin
            rr = w_eff - div_rsp.remainder;
        end
        else
        begin
            rr = '0;
        end
    end

    assign fl_calc = run_low_reg[fwh_pkg::RUN_W-1] ? (-q_s - fwh_pkg::quo_t'(rem_nz)) : q_s;
    assign lo_calc = fwh_pkg::quo_t'(run_low_reg) - fwh_pkg::quo_t'(rr);
    assign ce_calc = run_high_reg[fwh_pkg::RUN_W-1] ? (-q_s) : (q_s + fwh_pkg::quo_t'(rem_nz));

    // bins - 1 = ceil(max/w) - floor(min/w), never negative
    assign span     = fwh_pkg::off_t'(ce_reg) - fwh_pkg::off_t'(fl_reg);
    assign span_big = |span[fwh_pkg::OFF_W-1:fwh_pkg::BIN_AW];
    assign off_calc = fwh_pkg::off_t'(half) - fwh_pkg::off_t'(lo_reg);

    // Distance of a stored sample from the low edge; only the 0..64*w-1 window
    // needs the divider.
    assign d     = fwh_pkg::off_t'($signed(store_rdata)) + off_reg;
    assign d_neg = d[fwh_pkg::OFF_W-1];
    assign d_ext = {{(fwh_pkg::BINW_W + fwh_pkg::BIN_AW - fwh_pkg::OFF_W){1'b0}}, d};
    assign d_lim = {w_eff, {fwh_pkg::BIN_AW{1'b0}}};
    assign d_big = (d_ext >= d_lim);

    assign q_idx         = div_rsp.quotient[fwh_pkg::BIN_AW-1:0];
    assign q_idx_clamped = (q_idx > last_idx_reg) ? last_idx_reg : q_idx;

    always_comb
    begin
        div_req.start      = 1'b0;
        div_req.short_mode = 1'b0;
        div_req.dividend   = run_mag;
        div_req.divisor    = w_eff;
        case (state_reg)
            LO_GO, HI_GO:
            begin
                div_req.start = 1'b1;
            end
            S_IDX:
            begin
                div_req.start      = !d_neg && !d_big;
                div_req.short_mode = 1'b1;
                div_req.dividend   = d[fwh_pkg::DIV_W-1:0];
            end
            O_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = fwh_pkg::div_word_t'({cnt_val, {fwh_pkg::FRAC_SHIFT{1'b0}}});
                div_req.divisor  = fwh_pkg::width_t'(total_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    fwh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            bin_width_reg    <= fwh_pkg::BIN_WIDTH_RESET;
            total_reg        <= '0;
            run_low_reg      <= '0;
            run_high_reg     <= '0;
            fl_reg           <= '0;
            ce_reg           <= '0;
            lo_reg           <= '0;
            off_reg          <= '0;
            last_idx_reg     <= '0;
            clamped_reg      <= 1'b0;
            k_reg            <= '0;
            bin_idx_reg      <= '0;
            out_idx_reg      <= '0;
            cnt_reg          <= '0;
            edge_reg         <= '0;
            valid_reg        <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                bin_width_reg <= cfg_data;
            end
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        if (store_we)
                        begin
                            total_reg <= total_reg + fwh_pkg::total_t'(1);
                            if ((total_reg == '0) || (v < run_low_reg))
                            begin
                                run_low_reg <= v;
                            end
                            if ((total_reg == '0) || (v > run_high_reg))
                            begin
                                run_high_reg <= v;
                            end
                        end
                        if (item.last_sample)
                        begin
                            state_reg <= LO_GO;
                        end
                    end
                end
                LO_GO:
                begin
                    state_reg <= LO_WAIT;
                end
                LO_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        fl_reg    <= fl_calc;
                        lo_reg    <= lo_calc;
                        state_reg <= HI_GO;
                    end
                end
                HI_GO:
                begin
                    state_reg <= HI_WAIT;
                end
                HI_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ce_reg    <= ce_calc;
                        state_reg <= NBINS;
                    end
                end
                NBINS:
                begin
                    last_idx_reg <= span_big ? '1 : span[fwh_pkg::BIN_AW-1:0];
                    clamped_reg  <= span_big;
                    off_reg      <= off_calc;
                    edge_reg     <= fwh_pkg::edge_t'(lo_reg);
                    k_reg        <= '0;
                    out_idx_reg  <= '0;
                    state_reg    <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_IDX;
                end
                S_IDX:
                begin
                    if (d_neg)
                    begin
                        bin_idx_reg <= '0;
                        state_reg   <= C_RD;
                    end
                    else if (d_big)
                    begin
                        bin_idx_reg <= last_idx_reg;
                        state_reg   <= C_RD;
                    end
                    else
                    begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        bin_idx_reg <= q_idx_clamped;
                        state_reg   <= C_RD;
                    end
                end
                C_RD:
                begin
                    state_reg <= C_WR;
                end
                C_WR:
                begin
                    valid_reg[bin_idx_reg] <= 1'b1;
                    if ((k_reg + fwh_pkg::total_t'(1)) == total_reg)
                    begin
                        state_reg <= O_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + fwh_pkg::total_t'(1);
                        state_reg <= S_RD;
                    end
                end
                O_RD:
                begin
                    state_reg <= O_DIV;
                end
                O_DIV:
                begin
                    cnt_reg   <= cnt_val;
                    state_reg <= O_WAIT;
                end
                O_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg.bin_low      <= edge_reg;
                        result_reg.bin_count    <= cnt_reg;
                        result_reg.bin_fraction <= div_rsp.quotient[fwh_pkg::FRAC_W-1:0];
                        result_reg.span_clamped <= clamped_reg;
                        result_reg.last_bin     <= (out_idx_reg == last_idx_reg);
                        result_valid_reg        <= 1'b1;
                        edge_reg <= edge_reg + fwh_pkg::edge_t'(w_eff);
                        if (out_idx_reg == last_idx_reg)
                        begin
                            // run done: empty the set for the next one
                            total_reg    <= '0;
                            run_low_reg  <= '0;
                            run_high_reg <= '0;
                            valid_reg    <= '0;
                            state_reg    <= IDLE;
                        end
                        else
                        begin
                            out_idx_reg <= out_idx_reg + fwh_pkg::bin_idx_t'(1);
                            state_reg   <= O_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign run_idle = (state_reg == IDLE) && (total_reg == '0) && (valid_reg == '0);

    `FWH_ASSERT_NEVER(top_total_bound, clk, rst_n, total_reg > fwh_pkg::TOTAL_MAX)
    `FWH_ASSERT(top_bin_in_range, clk, rst_n, cnt_we, bin_idx_reg <= last_idx_reg)
    `FWH_ASSERT(top_last_bin_idle, clk, rst_n, result_valid_reg && result_reg.last_bin, run_idle)

endmodule

// ----- hw/rtl/fwh_ram.sv -----
`timescale 1ns / 1ps

module fwh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/fwh_div.sv -----
`timescale 1ns / 1ps
`include "fixed_width_histogram_assert.svh"

// Unsigned restoring divider, one quotient bit per cycle.
// Short mode preloads the upper dividend bits as remainder and runs BIN_AW steps.
module fwh_div (
    input  logic              clk,
    input  logic              rst_n,
    input  fwh_pkg::div_req_t req,
    output fwh_pkg::div_rsp_t rsp
);

    fwh_pkg::width_t                rem_reg, rem_next;
    fwh_pkg::div_word_t             quo_reg, quo_next;
    fwh_pkg::width_t                dvs_reg, dvs_next;
    fwh_pkg::div_cnt_t              cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [fwh_pkg::BINW_W:0]       shifted;
    logic [fwh_pkg::BINW_W+1:0]     diff;

    assign shifted = {rem_reg, quo_reg[fwh_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvs_next  = req.divisor;
            busy_next = 1'b1;
            if (req.short_mode)
            begin
                rem_next = fwh_pkg::width_t'(req.dividend >> fwh_pkg::BIN_AW);
                quo_next = req.dividend << (fwh_pkg::DIV_W - fwh_pkg::BIN_AW);
                cnt_next = fwh_pkg::div_cnt_t'(fwh_pkg::BIN_AW);
            end
            else
            begin
                rem_next = '0;
                quo_next = req.dividend;
                cnt_next = fwh_pkg::div_cnt_t'(fwh_pkg::DIV_W);
            end
        end
        else if (busy_reg)
        begin
            if (!diff[fwh_pkg::BINW_W+1])
            begin
                rem_next = diff[fwh_pkg::BINW_W-1:0];
            end
            else
            begin
                rem_next = shifted[fwh_pkg::BINW_W-1:0];
            end
            quo_next = {quo_reg[fwh_pkg::DIV_W-2:0], ~diff[fwh_pkg::BINW_W+1]};
            cnt_next = cnt_reg - fwh_pkg::div_cnt_t'(1);
            if (cnt_reg == fwh_pkg::div_cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `FWH_ASSERT(div_no_restart, clk, rst_n, req.start, !busy_reg)
    `FWH_ASSERT(div_rem_bound, clk, rst_n, done_reg, rem_reg < dvs_reg)
    `FWH_ASSERT_NEXT(div_start_runs, clk, rst_n, req.start, busy_reg)
    `FWH_ASSERT_NEXT(div_done_pulse, clk, rst_n, done_reg, !done_reg)

endmodule

// ----- dv/fixed_width_histogram_test.sv -----
`timescale 1ns / 1ps

module fixed_width_histogram_test;

    localparam int     RANDOM_ITEMS = 385;
    localparam int     QUIET_CYCLES = 40;    // settle time before a bin_width write
    localparam int     END_CYCLES   = 100;   // watch for stray results at the end
    localparam int     MAX_REPORTS  = 10;
    localparam longint WIDTH_CAP    = longint'(fwh_pkg::WIDTH_MAX);

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    fwh_pkg::item_t    item;
    logic              cfg_we;
    fwh_pkg::width_t   cfg_data;
    logic              bin_valid;
    fwh_pkg::result_t  bin_out;

    fixed_width_histogram DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (bin_valid),
        .result       (bin_out)
    );

    // Histogram shadow: bin width, current set and per-bin expectations
    fwh_pkg::width_t   width_reg;
    fwh_pkg::sample_t  set_samples [fwh_pkg::MAX_SAMPLES];
    int unsigned       set_size;
    longint            set_low;                // min of sample + half
    longint            set_high;               // max of sample + half
    fwh_pkg::result_t  pending_bins [$];
    int                mismatch_count;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if (a % b < 0)
            q--;
        return q;
    endfunction

    function automatic longint ceil_div(longint a, longint b);
        longint q;
        q = a / b;
        if (a % b > 0)
            q++;
        return q;
    endfunction

    // Width actually used by the block: register clamped to 2..2^30.
    function automatic longint used_width();
        longint w;
        w = longint'(width_reg);
        if (w < 2)
            w = 2;
        if (w > WIDTH_CAP)
            w = WIDTH_CAP;
        return w;
    endfunction

    // Fold one accepted request into the set; on last_sample, bin the set and
    // queue one expected result per bin, then start a fresh set.
    task automatic fold_sample(input fwh_pkg::item_t it);
        longint           w;
        longint           half;
        longint           v;
        longint           lo;
        longint           hi;
        longint           nbins;
        longint           idx;
        longint           cnt;
        longint           low_edge;
        bit               clamped;
        int unsigned      counts [fwh_pkg::MAX_BINS];
        fwh_pkg::result_t r;

        w    = used_width();
        half = w / 2;
        // Store full: the sample is dropped, but last_sample still counts.
        if (set_size < fwh_pkg::MAX_SAMPLES)
        begin
            v = longint'(signed'(it.sample)) + half;
            set_samples[set_size] = it.sample;
            if (set_size == 0)
            begin
                set_low  = v;
                set_high = v;
            end
            else
            begin
                if (v < set_low)
                    set_low = v;
                if (v > set_high)
                    set_high = v;
            end
            set_size++;
        end
        if (!it.last_sample)
            return;

        lo      = floor_div(set_low, w) * w;
        hi      = ceil_div(set_high, w) * w;
        nbins   = (hi - lo) / w + 1;
        clamped = 1'b0;
        if (nbins > fwh_pkg::MAX_BINS)
        begin
            nbins   = fwh_pkg::MAX_BINS;
            clamped = 1'b1;
        end
        foreach (counts[b])
            counts[b] = 0;
        for (int k = 0; k < set_size; k++)
        begin
            idx = floor_div(longint'(signed'(set_samples[k])) - lo + half, w);
            if (idx < 0)
                idx = 0;
            if (idx > nbins - 1)
                idx = nbins - 1;   // span too wide: overflow piles into the top bin
            counts[idx]++;
        end
        for (longint i = 0; i < nbins; i++)
        begin
            cnt            = longint'(counts[i]);
            low_edge       = i * w + lo;
            r.bin_low      = fwh_pkg::edge_t'(low_edge);
            r.bin_count    = fwh_pkg::count_t'(cnt);
            r.bin_fraction = fwh_pkg::frac_t'((cnt << fwh_pkg::FRAC_SHIFT)
                                              / longint'(set_size));
            r.span_clamped = clamped;
            r.last_bin     = (i == nbins - 1);
            pending_bins.push_back(r);
        end
        set_size = 0;
        set_low  = 0;
        set_high = 0;
    endtask

    // Result checker: outputs are registered, sample them on the rising edge
    always @(posedge clk)
    begin
        fwh_pkg::result_t want;
        if (rst_n && bin_valid)
        begin
            if (pending_bins.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected bin: low %0d count %0d frac %0d clamp %0b last %0b",
                             bin_out.bin_low, bin_out.bin_count, bin_out.bin_fraction,
                             bin_out.span_clamped, bin_out.last_bin);
            end
            else
            begin
                want = pending_bins.pop_front();
                if (bin_out.bin_low !== want.bin_low
                    || bin_out.bin_count !== want.bin_count
                    || bin_out.bin_fraction !== want.bin_fraction
                    || bin_out.span_clamped !== want.span_clamped
                    || bin_out.last_bin !== want.last_bin)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("bin mismatch at %0t", $realtime);
                        $display("  expected: low %0d count %0d frac %0d clamp %0b last %0b",
                                 want.bin_low, want.bin_count, want.bin_fraction,
                                 want.span_clamped, want.last_bin);
                        $display("  actual:   low %0d count %0d frac %0d clamp %0b last %0b",
                                 bin_out.bin_low, bin_out.bin_count, bin_out.bin_fraction,
                                 bin_out.span_clamped, bin_out.last_bin);
                    end
                end
            end
        end
    end

    // Request side. All tasks start and end on a falling edge.

    // One request: hold start until a rising edge sees busy low.
    task automatic send_item(input fwh_pkg::sample_t s, input logic last);
        fwh_pkg::item_t it;
        it.sample      = s;
        it.last_sample = last;
        start = 1'b1;
        item  = it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        fold_sample(it);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Mostly no gap, some short ones, a few long ones.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send a whole set; the final request carries last_sample.
    task automatic send_set(input fwh_pkg::sample_t vals [$], input bit gaps);
        foreach (vals[k])
        begin
            send_item(vals[k], k == vals.size() - 1);
            if (gaps)
                repeat (rand_gap()) @(negedge clk);
        end
    endtask

    // Sender pause: let every queued bin come out, then let the block settle.
    task automatic wait_bins_drained(input int settle);
        while (pending_bins.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // bin_width write; only called with the block idle.
    task automatic write_bin_width(input fwh_pkg::width_t val);
        wait_bins_drained(QUIET_CYCLES);
        cfg_we   = 1'b1;
        cfg_data = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        width_reg = val;
    endtask

    function automatic fwh_pkg::sample_t clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint rand_below(input longint n);
        longint unsigned r;
        r = {$urandom, $urandom};
        return longint'(r % n);
    endfunction

    // Tests

    // Reset width 256 (half 128): samples right on the half-bin boundaries,
    // then a one-sample set, which fills a single bin to 65536.
    task automatic test_reset_width();
        send_set('{32'sd0, 32'sd127, 32'sd128, -32'sd129}, 1'b1);
        send_set('{32'sd1234}, 1'b0);
    endtask

    // Full-range samples overflow 64 bins and get clamped; then two samples at the top.
    task automatic test_sample_extremes();
        send_set('{32'h8000_0000, 32'h7FFF_FFFF}, 1'b1);
        send_set('{32'h7FFF_FFFF, 32'h7FFF_FFFE}, 1'b0);
    endtask

    // Widths below 2 and above 2^30 get clamped; an odd width floors half.
    task automatic test_width_limits();
        write_bin_width('0);
        send_set('{-32'sd2, 32'sd0, 32'sd1}, 1'b1);
        write_bin_width(31'd1);
        send_set('{-32'sd1, 32'sd2}, 1'b0);
        write_bin_width(31'd3);
        send_set('{-32'sd1, 32'sd0, 32'sd1}, 1'b1);
        write_bin_width(fwh_pkg::WIDTH_MAX);
        send_set('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1);
        write_bin_width(31'h7FFF_FFFF);
        send_set('{32'h8000_0000, 32'h7FFF_FFFF}, 1'b0);
    endtask

    // Maximum lands exactly on a bin edge: the bin count must not overshoot.
    task automatic test_exact_edge();
        write_bin_width(fwh_pkg::BIN_WIDTH_RESET);
        send_set('{32'sd128, 32'sd384}, 1'b1);
    endtask

    // Random sets with random content and widths. Most sets are clustered;
    // others hit clamping and bin edges.
    task automatic test_random_sets();
        fwh_pkg::sample_t vals [$];
        int               sent;
        int               set_count;
        int               n;
        int               mode;
        int               r;
        bit               gaps;
        longint           w;
        longint           base;
        longint           spread;
        fwh_pkg::width_t  new_width;

        sent      = 0;
        set_count = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Re-pick the width every few sets (also forces a drained pause).
            if (set_count % 4 == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    new_width = fwh_pkg::width_t'($urandom_range(0, 1));
                else if (r < 50)
                    new_width = fwh_pkg::width_t'($urandom_range(2, 64));
                else if (r < 75)
                    new_width = fwh_pkg::width_t'($urandom_range(65, 100000));
                else if (r < 90)
                    new_width = fwh_pkg::width_t'($urandom);
                else if (r < 95)
                    new_width = fwh_pkg::WIDTH_MAX;
                else
                    new_width = 31'h7FFF_FFFF;
                write_bin_width(new_width);
            end
            w = used_width();

            r = $urandom_range(0, 9);
            if (r < 7)
                n = $urandom_range(1, 12);
            else if (r < 9)
                n = $urandom_range(13, 40);
            else
                n = 1;
            mode   = $urandom_range(0, 99);
            base   = longint'(signed'(fwh_pkg::sample_t'($urandom)));
            spread = w * $urandom_range(0, 66) + $urandom_range(0, 7);
            vals.delete();
            for (int k = 0; k < n; k++)
            begin
                if (mode < 50)
                    vals.push_back(clip32(base + rand_below(spread + 1)));
                else if (mode < 70)
                    vals.push_back(fwh_pkg::sample_t'($urandom));
                else if (mode < 85)
                begin
                    case ($urandom_range(0, 4))
                        0:       vals.push_back(32'h8000_0000);
                        1:       vals.push_back(32'h7FFF_FFFF);
                        2:       vals.push_back(32'h0000_0000);
                        3:       vals.push_back(32'hFFFF_FFFF);
                        default: vals.push_back(fwh_pkg::sample_t'($urandom));
                    endcase
                end
                else
                begin
                    // Right around half-bin boundaries.
                    vals.push_back(clip32(floor_div(base, w) * w
                                          + longint'($urandom_range(0, 10)) * w
                                          - w / 2 + longint'($urandom_range(0, 2)) - 1));
                end
            end
            gaps = ($urandom_range(0, 3) != 0);
            send_set(vals, gaps);
            sent += n;
            set_count++;
            if ($urandom_range(0, 7) == 0)
                wait_bins_drained(0);
            else if (gaps)
                repeat (rand_gap()) @(negedge clk);
        end
    endtask

    // Sequencer
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        width_reg      = fwh_pkg::BIN_WIDTH_RESET;
        set_size       = 0;
        set_low        = 0;
        set_high       = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_width();
        test_sample_extremes();
        test_width_limits();
        test_exact_edge();
        test_random_sets();

        wait_bins_drained(END_CYCLES);
        if (mismatch_count == 0)
            $display("** fixed_width_histogram: PASSED **");
        else
            $display("** fixed_width_histogram: FAILED **");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("** fixed_width_histogram: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fwh_pkg.sv
hw/rtl/fwh_ram.sv
hw/rtl/fwh_div.sv
hw/rtl/fixed_width_histogram.sv
dv/fixed_width_histogram_test.sv
